// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers for the RTL, included by tgd_core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must never be true while out of reset
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
    else $error("assertion failed: never");

// ante implies cons in the same cycle
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// ante implies cons in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== hw/rtl/tgd_pkg.sv =====
`default_nettype none

package tgd_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Request codes
  typedef enum logic [1:0] {
    REQ_SAMPLE = 2'd0,
    REQ_WAKE   = 2'd1,
    REQ_SLEEP  = 2'd2
  } req_e;

  // Detection mode codes
  typedef enum logic [1:0] {
    MODE_OFF      = 2'd0,
    MODE_NORMAL   = 2'd1,
    MODE_INVERTED = 2'd2
  } mode_e;

  // Screen orientation codes
  typedef enum logic [1:0] {
    ORIENT_PORTRAIT  = 2'd0,
    ORIENT_INVERTED  = 2'd1,
    ORIENT_LAND_CW   = 2'd2,
    ORIENT_LAND_CCW  = 2'd3
  } orient_e;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TILT_MODE     = 3'd0,
    CFG_ORIENTATION   = 3'd1,
    CFG_READER_ACTIVE = 3'd2,
    CFG_RATE_THR      = 3'd3,
    CFG_NEUTRAL_THR   = 3'd4,
    CFG_COOLDOWN      = 3'd5,
    CFG_WAKE_SETTLE   = 3'd6,
    CFG_POLL_INTERVAL = 3'd7
  } cfg_idx_e;

  // Reset values
  localparam logic [14:0] RATE_THR_RST      = 15'd1920;
  localparam logic [14:0] NEUTRAL_THR_RST   = 15'd640;
  localparam logic [15:0] COOLDOWN_RST      = 16'd500;
  localparam logic [15:0] WAKE_SETTLE_RST   = 16'd100;
  localparam logic [15:0] POLL_INTERVAL_RST = 16'd50;

  typedef struct packed {
    logic [1:0]  tilt_mode;
    logic [1:0]  orientation_sel;
    logic        reader_active;
    logic [14:0] rate_threshold;
    logic [14:0] neutral_threshold;
    logic [15:0] cool_span;
    logic [15:0] wake_settle_ms;
    logic [15:0] poll_span;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [31:0]        now_ms;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
  } in_word_t;

  typedef struct packed {
    logic forward_pulse;
    logic back_pulse;
    logic sample_used;
    logic holding_tilt;
  } out_word_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tilt_gesture_detector_top.sv =====
// Channel   Direction  Handshake             Word
// in        input      in_valid_i/in_stall_o   tgd_pkg::in_word_t
// out       output     out_valid_o/out_stall_i tgd_pkg::out_word_t
// cfg       input      cfg_valid_i/cfg_ready_o index + 16-bit data
//
// One word per cycle unless the output stalls; input register, then result register.
// The detector state updates in the cycle a word moves from the input to the result register.
// rst_ni clears all control state and restores the register reset values at once.
// A stalled output holds its word; the input register still takes a word while empty.
// cfg_ready_o is always high.
`default_nettype none

module tilt_gesture_detector_top #(
  parameter int unsigned TIME_BITS = 32
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output      logic                            in_stall_o,
  input  wire tgd_pkg::in_word_t               in_data_i,
  output      logic                            out_valid_o,
  input  wire logic                            out_stall_i,
  output tgd_pkg::out_word_t                   out_data_o,
  input  wire logic                            cfg_valid_i,
  output      logic                            cfg_ready_o,
  input  wire logic [tgd_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [tgd_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  tgd_pkg::cfg_t      cfg;
  tgd_pkg::in_word_t  in_q;
  tgd_pkg::out_word_t out_q, res;
  logic in_valid_q, out_valid_q;
  logic advance, fire;

  assign cfg_ready_o = 1'b1;

  tgd_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_valid_i && cfg_ready_o),
    .wr_idx_i  (cfg_index_i),
    .wr_data_i (cfg_data_i),
    .cfg_o     (cfg)
  );

  // Flow control between the two registers
  assign advance    = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;

  tgd_core #(.TIME_BITS(TIME_BITS)) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (in_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_data_i;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== hw/rtl/tgd_cfg_regs.sv =====
`default_nettype none

module tgd_cfg_regs (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            wr_en_i,
  input  wire logic [tgd_pkg::CFG_IDX_W-1:0]   wr_idx_i,
  input  wire logic [tgd_pkg::CFG_DATA_W-1:0]  wr_data_i,
  output tgd_pkg::cfg_t                        cfg_o
);

  tgd_pkg::cfg_t cfg_q;

  // Register file, one write per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tilt_mode         <= tgd_pkg::MODE_OFF;
      cfg_q.orientation_sel   <= tgd_pkg::ORIENT_PORTRAIT;
      cfg_q.reader_active     <= 1'b0;
      cfg_q.rate_threshold    <= tgd_pkg::RATE_THR_RST;
      cfg_q.neutral_threshold <= tgd_pkg::NEUTRAL_THR_RST;
      cfg_q.cool_span         <= tgd_pkg::COOLDOWN_RST;
      cfg_q.wake_settle_ms    <= tgd_pkg::WAKE_SETTLE_RST;
      cfg_q.poll_span         <= tgd_pkg::POLL_INTERVAL_RST;
    end else if (wr_en_i) begin
      unique case (tgd_pkg::cfg_idx_e'(wr_idx_i))
        tgd_pkg::CFG_TILT_MODE:     cfg_q.tilt_mode         <= wr_data_i[1:0];
        tgd_pkg::CFG_ORIENTATION:   cfg_q.orientation_sel   <= wr_data_i[1:0];
        tgd_pkg::CFG_READER_ACTIVE: cfg_q.reader_active     <= wr_data_i[0];
        tgd_pkg::CFG_RATE_THR:      cfg_q.rate_threshold    <= wr_data_i[14:0];
        tgd_pkg::CFG_NEUTRAL_THR:   cfg_q.neutral_threshold <= wr_data_i[14:0];
        tgd_pkg::CFG_COOLDOWN:      cfg_q.cool_span         <= wr_data_i;
        tgd_pkg::CFG_WAKE_SETTLE:   cfg_q.wake_settle_ms    <= wr_data_i;
        tgd_pkg::CFG_POLL_INTERVAL: cfg_q.poll_span         <= wr_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== hw/rtl/tgd_core.sv =====
`default_nettype none

`include "assert_macros.svh"

module tgd_core #(
  parameter int unsigned TIME_BITS = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              fire_i,
  input  wire tgd_pkg::in_word_t item_i,
  input  wire tgd_pkg::cfg_t     cfg_i,
  output tgd_pkg::out_word_t     res_o
);

  typedef logic [TIME_BITS-1:0] time_t;

  // Negate with -32768 saturating to 32767
  function automatic logic signed [15:0] neg_sat(input logic signed [15:0] v);
    logic signed [15:0] r;
    if (v == 16'sh8000) r = 16'sh7FFF;
    else                r = -v;
    return r;
  endfunction

  logic  held_q, held_d;
  time_t trig_q, trig_d;
  time_t wake_q, wake_d;
  time_t poll_q, poll_d;

  time_t now;
  time_t since_wake, since_poll, since_trig;
  logic  settle_ok, poll_ok, cool_ok, enabled, inv, do_neg;
  logic signed [15:0] src, axis, axis_neg;
  logic signed [16:0] axis_ext, thr_pos, thr_neg;
  logic [14:0] mag;
  logic fwd_hit, back_hit;

  // Time window checks, all modulo 2^TIME_BITS
  assign now        = TIME_BITS'(item_i.now_ms);
  assign since_wake = now - wake_q;
  assign since_poll = now - poll_q;
  assign since_trig = now - trig_q;
  assign settle_ok  = since_wake >= TIME_BITS'(cfg_i.wake_settle_ms);
  assign poll_ok    = since_poll >= TIME_BITS'(cfg_i.poll_span);
  assign cool_ok    = since_trig >= TIME_BITS'(cfg_i.cool_span);
  assign enabled    = (cfg_i.tilt_mode != tgd_pkg::MODE_OFF) && cfg_i.reader_active;

  // Axis pick: Y in landscape, X otherwise; sign from orientation and mode
  assign inv = (cfg_i.tilt_mode == tgd_pkg::MODE_INVERTED);
  always_comb begin
    case (tgd_pkg::orient_e'(cfg_i.orientation_sel))
      tgd_pkg::ORIENT_PORTRAIT: do_neg = inv;
      tgd_pkg::ORIENT_INVERTED: do_neg = !inv;
      tgd_pkg::ORIENT_LAND_CW:  do_neg = !inv;
      default:                  do_neg = inv;
    endcase
  end
  assign src      = cfg_i.orientation_sel[1] ? item_i.rate_y : item_i.rate_x;
  assign axis     = do_neg ? neg_sat(src) : src;
  assign axis_neg = neg_sat(axis);
  assign mag      = axis[15] ? axis_neg[14:0] : axis[14:0];

  // Threshold compares on 17-bit signed values
  assign axis_ext = {axis[15], axis};
  assign thr_pos  = $signed({2'b00, cfg_i.rate_threshold});
  assign thr_neg  = -thr_pos;
  assign fwd_hit  = axis_ext > thr_pos;
  assign back_hit = axis_ext < thr_neg;

  // Next state and result
  always_comb begin
    held_d = held_q;
    trig_d = trig_q;
    wake_d = wake_q;
    poll_d = poll_q;
    res_o  = '0;
    if (item_i.req_type == tgd_pkg::REQ_WAKE) begin
      wake_d = now;
      trig_d = now;
      poll_d = now;
    end else if (item_i.req_type == tgd_pkg::REQ_SLEEP) begin
      held_d = 1'b0;
    end else if (item_i.req_type == tgd_pkg::REQ_SAMPLE && enabled &&
                 settle_ok && poll_ok) begin
      res_o.sample_used = 1'b1;
      poll_d = now;
      if (held_q) begin
        if (mag < cfg_i.neutral_threshold) held_d = 1'b0;
      end else if (cool_ok) begin
        if (fwd_hit) begin
          res_o.forward_pulse = 1'b1;
          held_d = 1'b1;
          trig_d = now;
        end else if (back_hit) begin
          res_o.back_pulse = 1'b1;
          held_d = 1'b1;
          trig_d = now;
        end
      end
    end
    res_o.holding_tilt = held_d;
  end

  // Detector state, updated once per evaluated word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= 1'b0;
      trig_q <= '0;
      wake_q <= '0;
      poll_q <= '0;
    end else if (fire_i) begin
      held_q <= held_d;
      trig_q <= trig_d;
      wake_q <= wake_d;
      poll_q <= poll_d;
    end
  end

  `ASSERT_NEVER(a_one_pulse, clk_i, rst_ni, res_o.forward_pulse && res_o.back_pulse)
  `ASSERT_IMPL(a_pulse_used, clk_i, rst_ni, res_o.forward_pulse || res_o.back_pulse, res_o.sample_used)
  `ASSERT_NEXT(a_pulse_holds, clk_i, rst_ni, fire_i && (res_o.forward_pulse || res_o.back_pulse), held_q)
  `ASSERT_IMPL(a_used_is_sample, clk_i, rst_ni, res_o.sample_used, item_i.req_type == tgd_pkg::REQ_SAMPLE)

endmodule

`default_nettype wire

// ===== tb/tilt_gesture_detector_top_tb.sv =====
`timescale 1ns / 1ps

module tilt_gesture_detector_top_tb;

  // Codes with no name in the package
  localparam logic [1:0] REQ_RESERVED   = 2'd3;  // ignored request
  localparam logic [1:0] MODE_AS_NORMAL = 2'd3;  // undefined mode, behaves as normal
  localparam int         CYCLE_LIMIT    = 200000;

  // Tilt predictor plus queue of expected result words
  class tilt_scoreboard;
    tgd_pkg::cfg_t      cfg;
    bit                 held;
    logic [31:0]        trig_t;
    logic [31:0]        wake_t;
    logic [31:0]        poll_t;
    tgd_pkg::out_word_t want_q[$];
    int                 mismatches;
    int                 checked;
    int                 fwd_cnt;
    int                 back_cnt;
    int                 used_cnt;

    function new();
      cfg.tilt_mode         = tgd_pkg::MODE_OFF;
      cfg.orientation_sel   = tgd_pkg::ORIENT_PORTRAIT;
      cfg.reader_active     = 1'b0;
      cfg.rate_threshold    = tgd_pkg::RATE_THR_RST;
      cfg.neutral_threshold = tgd_pkg::NEUTRAL_THR_RST;
      cfg.cool_span         = tgd_pkg::COOLDOWN_RST;
      cfg.wake_settle_ms    = tgd_pkg::WAKE_SETTLE_RST;
      cfg.poll_span         = tgd_pkg::POLL_INTERVAL_RST;
      held   = 1'b0;
      trig_t = '0;
      wake_t = '0;
      poll_t = '0;
    endfunction

    function void write_reg(logic [tgd_pkg::CFG_IDX_W-1:0] idx, logic [15:0] d);
      case (idx)
        tgd_pkg::CFG_TILT_MODE:     cfg.tilt_mode         = d[1:0];
        tgd_pkg::CFG_ORIENTATION:   cfg.orientation_sel   = d[1:0];
        tgd_pkg::CFG_READER_ACTIVE: cfg.reader_active     = d[0];
        tgd_pkg::CFG_RATE_THR:      cfg.rate_threshold    = d[14:0];
        tgd_pkg::CFG_NEUTRAL_THR:   cfg.neutral_threshold = d[14:0];
        tgd_pkg::CFG_COOLDOWN:      cfg.cool_span         = d;
        tgd_pkg::CFG_WAKE_SETTLE:   cfg.wake_settle_ms    = d;
        default:                    cfg.poll_span         = d;
      endcase
    endfunction

    // negation that saturates the most negative rate
    function int flip(int v);
      return (v == -32768) ? 32767 : -v;
    endfunction

    // work out the result word for an accepted input word and queue it
    function void note_input(tgd_pkg::in_word_t w);
      tgd_pkg::out_word_t r;
      logic signed [15:0] rx;
      logic signed [15:0] ry;
      logic [31:0]        since_wake;
      logic [31:0]        since_poll;
      logic [31:0]        since_trig;
      int                 ax;
      int                 mag;
      int                 thr;
      bit                 inv;
      r          = '0;
      rx         = w.rate_x;
      ry         = w.rate_y;
      since_wake = w.now_ms - wake_t;
      since_poll = w.now_ms - poll_t;
      since_trig = w.now_ms - trig_t;
      thr        = int'(cfg.rate_threshold);
      case (w.req_type)
        tgd_pkg::REQ_WAKE: begin
          wake_t = w.now_ms;
          trig_t = w.now_ms;
          poll_t = w.now_ms;
        end
        tgd_pkg::REQ_SLEEP: held = 1'b0;
        tgd_pkg::REQ_SAMPLE: begin
          if (cfg.tilt_mode != tgd_pkg::MODE_OFF && cfg.reader_active &&
              since_wake >= cfg.wake_settle_ms && since_poll >= cfg.poll_span) begin
            r.sample_used = 1'b1;
            poll_t = w.now_ms;
            inv = (cfg.tilt_mode == tgd_pkg::MODE_INVERTED);
            case (cfg.orientation_sel)
              tgd_pkg::ORIENT_PORTRAIT: ax = inv ? flip(rx) : rx;
              tgd_pkg::ORIENT_INVERTED: ax = inv ? int'(rx) : flip(rx);
              tgd_pkg::ORIENT_LAND_CW:  ax = inv ? int'(ry) : flip(ry);
              default:                  ax = inv ? flip(ry) : ry;
            endcase
            mag = (ax < 0) ? flip(ax) : ax;
            if (held) begin
              if (mag < int'(cfg.neutral_threshold)) held = 1'b0;
            end else if (since_trig >= cfg.cool_span) begin
              if (ax > thr) begin
                r.forward_pulse = 1'b1;
                held = 1'b1;
                trig_t = w.now_ms;
              end else if (ax < -thr) begin
                r.back_pulse = 1'b1;
                held = 1'b1;
                trig_t = w.now_ms;
              end
            end
          end
        end
        default: ;
      endcase
      r.holding_tilt = held;
      fwd_cnt  += r.forward_pulse;
      back_cnt += r.back_pulse;
      used_cnt += r.sample_used;
      want_q.push_back(r);
    endfunction

    function void check_result(tgd_pkg::out_word_t got);
      tgd_pkg::out_word_t want;
      if (want_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result word %b arrived with none expected", got);
        return;
      end
      want = want_q.pop_front();
      checked++;
      if (got.forward_pulse !== want.forward_pulse || got.back_pulse !== want.back_pulse ||
          got.sample_used !== want.sample_used || got.holding_tilt !== want.holding_tilt) begin
        mismatches++;
        if (mismatches <= 10)
          $display("word %0d: exp fwd=%b back=%b used=%b hold=%b, got fwd=%b back=%b used=%b hold=%b",
                   checked, want.forward_pulse, want.back_pulse, want.sample_used,
                   want.holding_tilt, got.forward_pulse, got.back_pulse, got.sample_used,
                   got.holding_tilt);
      end
    endfunction
  endclass

  logic                           clk_i       = 1'b0;
  logic                           rst_ni      = 1'b0;
  logic                           in_valid_i  = 1'b0;
  tgd_pkg::in_word_t              in_data_i   = '0;
  logic                           out_stall_i = 1'b0;
  logic                           cfg_valid_i = 1'b0;
  logic [tgd_pkg::CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [tgd_pkg::CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                           in_stall_o;
  logic                           out_valid_o;
  tgd_pkg::out_word_t             out_data_o;
  logic                           cfg_ready_o;

  tilt_scoreboard sb;
  int             cycle_cnt  = 0;
  int             items_sent = 0;
  int             cfg_writes = 0;
  int             phases     = 0;
  bit             quiet      = 1'b0;
  bit             tx_gaps    = 1'b1;
  bit             rx_stalls  = 1'b1;
  logic [31:0]    now_t      = '0;

  tilt_gesture_detector_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // result checking
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
  end

  // receiver stall bursts
  initial begin : stall_gen
    int n;
    forever begin
      @(posedge clk_i);
      if (!quiet && rx_stalls && $urandom_range(0, 6) == 0) begin
        out_stall_i <= 1'b1;
        n = $urandom_range(1, 17);
        repeat (n) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // present one word, with an occasional gap first, and wait until it is taken
  task automatic send_word(input tgd_pkg::in_word_t w);
    int gap;
    if (!quiet && tx_gaps && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      gap = $urandom_range(1, 17);
      repeat (gap) @(posedge clk_i);
    end
    in_data_i  <= w;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(w);
    items_sent++;
  endtask

  task automatic send_req(input logic [1:0] req, input logic [31:0] t,
                          input logic [15:0] rx, input logic [15:0] ry);
    tgd_pkg::in_word_t w;
    w.req_type = req;
    w.now_ms   = t;
    w.rate_x   = rx;
    w.rate_y   = ry;
    send_word(w);
  endtask

  // hold off the sender until every expected word is back
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.want_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(input tgd_pkg::cfg_idx_e idx, input logic [15:0] d);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, d);
    cfg_writes++;
  endtask

  // write every register while idle; unused upper data bits carry junk
  task automatic apply_cfg(input tgd_pkg::cfg_t c);
    logic [15:0] junk;
    drain();
    junk = 16'($urandom);
    cfg_write(tgd_pkg::CFG_TILT_MODE, {junk[15:2], c.tilt_mode});
    cfg_write(tgd_pkg::CFG_ORIENTATION, {junk[13:0], c.orientation_sel});
    cfg_write(tgd_pkg::CFG_READER_ACTIVE, {junk[15:1], c.reader_active});
    cfg_write(tgd_pkg::CFG_RATE_THR, {junk[15], c.rate_threshold});
    cfg_write(tgd_pkg::CFG_NEUTRAL_THR, {junk[14], c.neutral_threshold});
    cfg_write(tgd_pkg::CFG_COOLDOWN, c.cool_span);
    cfg_write(tgd_pkg::CFG_WAKE_SETTLE, c.wake_settle_ms);
    cfg_write(tgd_pkg::CFG_POLL_INTERVAL, c.poll_span);
    cfg_valid_i <= 1'b0;
    phases++;
  endtask

  // kind 0: thresholds and spans at minimum, kind 1: at maximum, otherwise random
  function automatic tgd_pkg::cfg_t rand_cfg(int kind);
    tgd_pkg::cfg_t c;
    c.orientation_sel = 2'($urandom_range(0, 3));
    c.reader_active   = 1'b1;
    if (kind == 0) begin
      c.tilt_mode         = tgd_pkg::MODE_NORMAL;
      c.rate_threshold    = '0;
      c.neutral_threshold = '0;
      c.cool_span         = '0;
      c.wake_settle_ms    = '0;
      c.poll_span         = '0;
    end else if (kind == 1) begin
      c.tilt_mode         = tgd_pkg::MODE_INVERTED;
      c.rate_threshold    = '1;
      c.neutral_threshold = '1;
      c.cool_span         = '1;
      c.wake_settle_ms    = '1;
      c.poll_span         = '1;
    end else begin
      case ($urandom_range(0, 9))
        0:       c.tilt_mode = tgd_pkg::MODE_OFF;
        1, 2:    c.tilt_mode = MODE_AS_NORMAL;
        3, 4, 5: c.tilt_mode = tgd_pkg::MODE_INVERTED;
        default: c.tilt_mode = tgd_pkg::MODE_NORMAL;
      endcase
      c.reader_active     = ($urandom_range(0, 7) != 0);
      c.rate_threshold    = ($urandom_range(0, 3) == 0) ? 15'($urandom)
                                                        : 15'($urandom_range(0, 4000));
      c.neutral_threshold = ($urandom_range(0, 3) == 0) ? 15'($urandom)
                                                        : 15'($urandom_range(0, c.rate_threshold));
      c.cool_span         = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                                        : 16'($urandom_range(0, 600));
      c.wake_settle_ms    = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                                        : 16'($urandom_range(0, 200));
      c.poll_span         = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                                        : 16'($urandom_range(0, 100));
    end
    return c;
  endfunction

  // rates clustered at the extremes, the trigger edge and the release level
  function automatic logic [15:0] rand_rate();
    int v;
    int thr;
    int neu;
    thr = int'(sb.cfg.rate_threshold);
    neu = int'(sb.cfg.neutral_threshold);
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0:       v = -32768;
          1:       v = 32767;
          2:       v = -32767;
          default: v = 0;
        endcase
      end
      1, 2, 3: v = thr + int'($urandom_range(0, 4)) - 2;
      4, 5:    v = int'($urandom_range(0, neu + 2));
      default: v = int'($urandom_range(0, 65535)) - 32768;
    endcase
    if ($urandom_range(0, 1) == 1) v = -v;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  // one phase: a wake, then mostly samples on a forward-moving clock
  task automatic run_phase(input int n_items);
    tgd_pkg::in_word_t w;
    int                done;
    int                pick;
    int                poll;
    int                span;
    bit                paused;
    logic [31:0]       dt;
    paused = 1'b0;
    now_t  = now_t + $urandom_range(1, 1000);
    send_req(tgd_pkg::REQ_WAKE, now_t, rand_rate(), rand_rate());
    done = 1;
    while (done < n_items) begin
      poll = int'(sb.cfg.poll_span);
      span = int'(sb.cfg.cool_span) + int'(sb.cfg.wake_settle_ms) + 100;
      pick = $urandom_range(0, 99);
      if (pick < 84)      w.req_type = tgd_pkg::REQ_SAMPLE;
      else if (pick < 91) w.req_type = tgd_pkg::REQ_WAKE;
      else if (pick < 97) w.req_type = tgd_pkg::REQ_SLEEP;
      else                w.req_type = REQ_RESERVED;
      pick = $urandom_range(0, 19);
      if (pick == 0)      dt = '0;
      else if (pick < 4)  dt = $urandom_range(0, 2 * poll + 1);
      else if (pick < 13) dt = poll + $urandom_range(0, 200);
      else if (pick < 19) dt = $urandom_range(0, span);
      else                dt = $urandom;
      now_t    = now_t + dt;
      w.now_ms = now_t;
      w.rate_x = rand_rate();
      w.rate_y = rand_rate();
      send_word(w);
      if (w.req_type != REQ_RESERVED) done++;
      if (!paused && done >= n_items / 2) begin
        paused = 1'b1;
        drain();
      end
    end
  endtask

  initial begin : main_seq
    tgd_pkg::cfg_t c;
    int            ph;
    sb = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // detection off after reset, and the reserved request code
    send_req(tgd_pkg::REQ_SAMPLE, 32'd10, 16'sd32767, 16'sd0);
    send_req(REQ_RESERVED, 32'd20, 16'sh8000, 16'sh8000);

    // normal portrait with reset thresholds and timing
    c = sb.cfg;
    c.tilt_mode     = tgd_pkg::MODE_NORMAL;
    c.reader_active = 1'b1;
    apply_cfg(c);
    send_req(tgd_pkg::REQ_WAKE, 32'd1000, 16'sd0, 16'sd0);
    send_req(tgd_pkg::REQ_SAMPLE, 32'd1050, 16'sd32767, 16'sd0);   // inside settle window
    send_req(tgd_pkg::REQ_SAMPLE, 32'd1100, 16'sd32767, 16'sd0);   // inside cooldown
    send_req(tgd_pkg::REQ_SAMPLE, 32'd1600, 16'sd1921, 16'sd0);    // forward
    send_req(tgd_pkg::REQ_SAMPLE, 32'd1700, 16'sh8000, 16'sd0);    // held, saturated magnitude
    send_req(tgd_pkg::REQ_SAMPLE, 32'd1720, 16'sd0, 16'sd0);       // poll gate
    send_req(tgd_pkg::REQ_SAMPLE, 32'd1800, 16'sd639, 16'sd0);     // release
    send_req(tgd_pkg::REQ_SAMPLE, 32'd2400, -16'sd1921, 16'sd0);   // back
    send_req(tgd_pkg::REQ_SLEEP, 32'd2410, 16'sd0, 16'sd0);
    send_req(tgd_pkg::REQ_SAMPLE, 32'd2500, -16'sd1920, 16'sd0);   // exactly at threshold
    send_req(tgd_pkg::REQ_SAMPLE, 32'd2600, 16'sd1920, 16'sd0);
    send_req(tgd_pkg::REQ_WAKE, 32'hFFFF_FF00, 16'sd0, 16'sd0);    // timestamp wraps next
    send_req(tgd_pkg::REQ_SAMPLE, 32'h0000_0200, 16'sh8000, 16'sd0);
    send_req(tgd_pkg::REQ_SLEEP, 32'h0000_0210, 16'sd0, 16'sd0);

    // undefined mode acting as normal, inverted orientation, no timing gates
    c.tilt_mode       = MODE_AS_NORMAL;
    c.orientation_sel = tgd_pkg::ORIENT_INVERTED;
    c.cool_span       = '0;
    c.wake_settle_ms  = '0;
    c.poll_span       = '0;
    apply_cfg(c);
    send_req(tgd_pkg::REQ_SAMPLE, 32'h0000_0300, 16'sh8000, 16'sd0); // saturated forward
    send_req(tgd_pkg::REQ_SLEEP, 32'h0000_0310, 16'sd0, 16'sd0);
    c.tilt_mode       = tgd_pkg::MODE_INVERTED;
    c.orientation_sel = tgd_pkg::ORIENT_LAND_CW;
    apply_cfg(c);
    send_req(tgd_pkg::REQ_SAMPLE, 32'h0000_0320, 16'sd0, 16'sh8000);
    send_req(tgd_pkg::REQ_SLEEP, 32'h0000_0330, 16'sd0, 16'sd0);
    c.orientation_sel = tgd_pkg::ORIENT_LAND_CCW;
    apply_cfg(c);
    send_req(tgd_pkg::REQ_SAMPLE, 32'h0000_0340, 16'sd0, 16'sh8000);
    send_req(tgd_pkg::REQ_SLEEP, 32'h0000_0350, 16'sd0, 16'sd0);
    c.orientation_sel = tgd_pkg::ORIENT_PORTRAIT;
    c.reader_active   = 1'b0;
    apply_cfg(c);
    send_req(tgd_pkg::REQ_SAMPLE, 32'h0000_0360, 16'sd32767, 16'sd0); // reading view inactive
    now_t = 32'h0000_0400;

    // random phases; first two at the register extremes, last one without gaps or stalls
    for (ph = 0; ph < 8; ph++) begin
      c = rand_cfg(ph);
      apply_cfg(c);
      quiet     = (ph == 7);
      tx_gaps   = ($urandom_range(0, 3) != 0);
      rx_stalls = ($urandom_range(0, 3) != 0);
      run_phase(56);
    end

    drain();
    repeat (8) @(posedge clk_i);
    $display("%0d words sent, %0d results checked, %0d register writes over %0d settings",
             items_sent, sb.checked, cfg_writes, phases);
    $display("%0d samples evaluated, %0d forward and %0d back pulses, %0d mismatches",
             sb.used_cnt, sb.fwd_cnt, sb.back_cnt, sb.mismatches);
    if (sb.mismatches == 0 && sb.want_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/tgd_pkg.sv
hw/rtl/tgd_cfg_regs.sv
hw/rtl/tgd_core.sv
hw/rtl/tilt_gesture_detector_top.sv
tb/tilt_gesture_detector_top_tb.sv
